// File: rtl/ultrasonic_echo_ranger_avg_defines.svh
// assertion macros shared by the ranger rtl
`ifndef ULTRASONIC_ECHO_RANGER_AVG_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_AVG_DEFINES_SVH
`ifndef SYNTHESIS
`define UERA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uera assertion failed");
`define UERA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("uera assertion failed");
`else
`define UERA_ASSERT(lbl, clk, rst, prop)
`define UERA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/uera_pkg.sv
package uera_pkg;

  localparam int AVG_COUNT_DEF  = 10;
  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 16;
  localparam int SCALE_W   = 20;
  localparam int DIST_W    = 18;
  localparam int SUM_W     = 22;
  localparam int RND_BITS  = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_LOW  = 3'd0,
    REG_TRIG_HIGH = 3'd1,
    REG_LISTEN    = 3'd2,
    REG_LED_ON    = 3'd3,
    REG_LED_OFF   = 3'd4,
    REG_SCALE     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]   trigger_low_us;
    logic [LEN_W-1:0]   trigger_high_us;
    logic [LEN_W-1:0]   listen_timeout_us;
    logic [LEN_W-1:0]   led_on_us;
    logic [LEN_W-1:0]   led_off_us;
    logic [SCALE_W-1:0] scale_q24;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    trigger_low_us:    16'd2000,
    trigger_high_us:   16'd3000,
    listen_timeout_us: 16'd30000,
    led_on_us:         16'd10000,
    led_off_us:        16'd10000,
    scale_q24:         20'd287729
  };

  typedef struct packed {
    logic trigger_level;
    logic led_level;
    logic measure_done;
    logic no_echo;
  } flags_t;

endpackage

// File: rtl/uera_cfg.sv
module uera_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uera_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uera_pkg::SCALE_W-1:0]   cfg_data,
  output uera_pkg::cfg_t                 regs
);
  import uera_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRIG_LOW:  regs.trigger_low_us    <= cfg_data[LEN_W-1:0];
        REG_TRIG_HIGH: regs.trigger_high_us   <= cfg_data[LEN_W-1:0];
        REG_LISTEN:    regs.listen_timeout_us <= cfg_data[LEN_W-1:0];
        REG_LED_ON:    regs.led_on_us         <= cfg_data[LEN_W-1:0];
        REG_LED_OFF:   regs.led_off_us        <= cfg_data[LEN_W-1:0];
        REG_SCALE:     regs.scale_q24         <= cfg_data;
        default:       regs                   <= regs;
      endcase
    end
  end

endmodule

// File: rtl/uera_seq.sv
`include "ultrasonic_echo_ranger_avg_defines.svh"

module uera_seq #(
  parameter int TIMER_BITS = uera_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  echo_level,
  input  uera_pkg::cfg_t        regs,
  output logic                  out_valid,
  input  logic                  out_ready,
  output uera_pkg::flags_t      flags,
  output logic [TIMER_BITS-1:0] pulse
);
  import uera_pkg::*;

  typedef enum logic [2:0] {
    PH_LED_ON    = 3'd0,
    PH_LED_OFF   = 3'd1,
    PH_TRIG_LOW  = 3'd2,
    PH_TRIG_HIGH = 3'd3,
    PH_WAIT      = 3'd4,
    PH_PULSE     = 3'd5
  } phase_t;

  localparam int LW = (TIMER_BITS > LEN_W) ? TIMER_BITS : LEN_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LW-1:0] w;
    w = LW'(v);
    if (w > LW'(TMAX)) begin
      clamp_len = TMAX;
    end else begin
      clamp_len = TIMER_BITS'(w);
    end
  endfunction

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] phase_ticks, phase_ticks_next;
  logic [TIMER_BITS-1:0] pulse_ticks, pulse_ticks_next;
  flags_t                flags_next;
  logic [TIMER_BITS-1:0] pulse_next;

  phase_t                ph_s;
  logic [TIMER_BITS-1:0] ticks_s, pulse_s, cur_len;
  logic [TIMER_BITS-1:0] len_on, len_off, len_lo, len_hi, len_ls;
  logic                  last, accept;

  assign len_on  = clamp_len(regs.led_on_us);
  assign len_off = clamp_len(regs.led_off_us);
  assign len_lo  = clamp_len(regs.trigger_low_us);
  assign len_hi  = clamp_len(regs.trigger_high_us);
  assign len_ls  = clamp_len(regs.listen_timeout_us);

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ph_s    = phase;
    ticks_s = phase_ticks;
    pulse_s = pulse_ticks;
    if (!(phase inside {PH_LED_ON, PH_LED_OFF, PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT,
                        PH_PULSE})) begin
      ph_s    = PH_LED_ON;
      ticks_s = '0;
      pulse_s = '0;
    end
    // zero-length led and trigger phases take no tick
    if (ph_s == PH_LED_ON && len_on == '0) begin
      ph_s    = PH_LED_OFF;
      ticks_s = '0;
    end
    if (ph_s == PH_LED_OFF && len_off == '0) begin
      ph_s    = PH_TRIG_LOW;
      ticks_s = '0;
    end
    if (ph_s == PH_TRIG_LOW && len_lo == '0) begin
      ph_s    = PH_TRIG_HIGH;
      ticks_s = '0;
    end
    if (ph_s == PH_TRIG_HIGH && len_hi == '0) begin
      ph_s    = PH_WAIT;
      ticks_s = '0;
    end

    case (ph_s)
      PH_LED_ON:    cur_len = len_on;
      PH_LED_OFF:   cur_len = len_off;
      PH_TRIG_LOW:  cur_len = len_lo;
      PH_TRIG_HIGH: cur_len = len_hi;
      default:      cur_len = len_ls;
    endcase
    last = ((TIMER_BITS+1)'(ticks_s) + 1'b1) >= (TIMER_BITS+1)'(cur_len);

    phase_next       = ph_s;
    phase_ticks_next = ticks_s + 1'b1;
    pulse_ticks_next = pulse_s;
    pulse_next       = pulse_s;
    flags_next       = '0;

    case (ph_s)
      PH_LED_ON: begin
        flags_next.led_level = 1'b1;
        if (last) begin
          phase_next = PH_LED_OFF;
        end
      end
      PH_LED_OFF: begin
        if (last) begin
          phase_next = PH_TRIG_LOW;
        end
      end
      PH_TRIG_LOW: begin
        if (last) begin
          phase_next = PH_TRIG_HIGH;
        end
      end
      PH_TRIG_HIGH: begin
        flags_next.trigger_level = 1'b1;
        if (last) begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (last) begin
          flags_next.measure_done = 1'b1;
          flags_next.no_echo      = 1'b1;
        end else if (echo_level) begin
          phase_next       = PH_PULSE;
          pulse_ticks_next = TIMER_BITS'(1);
        end
      end
      PH_PULSE: begin
        if (!echo_level) begin
          flags_next.measure_done = 1'b1;
        end else if (last) begin
          flags_next.measure_done = 1'b1;
          flags_next.no_echo      = 1'b1;
        end else if (pulse_s != TMAX) begin
          pulse_ticks_next = pulse_s + 1'b1;
        end
      end
      default: begin
        phase_next = PH_LED_ON;
      end
    endcase

    if (ph_s != PH_WAIT && ph_s != PH_PULSE && last) begin
      phase_ticks_next = '0;
      pulse_ticks_next = '0;
    end
    if (flags_next.measure_done) begin
      phase_next       = PH_LED_ON;
      phase_ticks_next = '0;
      pulse_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LED_ON;
      phase_ticks <= '0;
      pulse_ticks <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        phase_ticks <= phase_ticks_next;
        pulse_ticks <= pulse_ticks_next;
        flags       <= flags_next;
        pulse       <= pulse_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  `UERA_ASSERT(a_finish_restarts, clk, rst, accept && flags_next.measure_done |=> phase == PH_LED_ON && phase_ticks == '0 && pulse_ticks == '0)
  `UERA_ASSERT(a_pulse_counted, clk, rst, phase == PH_PULSE |-> pulse_ticks != '0)
  `UERA_ASSERT(a_no_echo_done, clk, rst, out_valid && flags.no_echo |-> flags.measure_done)

endmodule

// File: rtl/uera_dist.sv
`include "ultrasonic_echo_ranger_avg_defines.svh"

module uera_dist #(
  parameter int TIMER_BITS = uera_pkg::TIMER_BITS_DEF,
  parameter int AVG_COUNT  = uera_pkg::AVG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  uera_pkg::flags_t             flags_in,
  input  logic [TIMER_BITS-1:0]        pulse,
  input  logic [uera_pkg::SCALE_W-1:0] scale,
  output logic                         out_valid,
  input  logic                         out_ready,
  output uera_pkg::flags_t             flags_out,
  output logic [uera_pkg::DIST_W-1:0]  distance,
  output logic                         avg_load,
  output logic [uera_pkg::SUM_W-1:0]   avg_sum
);
  import uera_pkg::*;

  localparam int PW    = TIMER_BITS + SCALE_W;
  localparam int QW    = PW + 1 - RND_BITS;
  localparam int XW    = QW + DIST_W;
  localparam int CNT_W = $clog2(AVG_COUNT + 1);

  // product stage
  logic          b_valid, b_ready;
  flags_t        b_flags;
  logic [PW-1:0] b_prod;

  // accumulate stage
  logic              c_ready, c_load;
  logic [PW:0]       rnd;
  logic [XW-1:0]     qx;
  logic [DIST_W-1:0] d;
  logic              ok;
  logic [SUM_W-1:0]  distance_sum, sum_total;
  logic [CNT_W-1:0]  sample_count, cnt_inc;
  logic              wrap;

  assign c_ready  = !out_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign in_ready = b_ready;
  assign c_load   = b_valid && c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_valid && b_ready) begin
      b_valid <= 1'b1;
      b_flags <= flags_in;
      b_prod  <= PW'(pulse) * PW'(scale);
    end else if (c_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_comb begin
    rnd       = (PW+1)'(b_prod) + (PW+1)'(1 << (RND_BITS - 1));
    qx        = XW'(rnd[PW:RND_BITS]);
    ok        = b_flags.measure_done && !b_flags.no_echo;
    if (!ok) begin
      d = '0;
    end else if (qx > XW'(DIST_MAX)) begin
      d = DIST_MAX;
    end else begin
      d = qx[DIST_W-1:0];
    end
    sum_total = distance_sum + SUM_W'(d);
    cnt_inc   = sample_count + 1'b1;
    wrap      = cnt_inc >= CNT_W'(AVG_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      distance     <= '0;
      distance_sum <= '0;
      sample_count <= '0;
    end else begin
      if (c_load) begin
        out_valid <= 1'b1;
        flags_out <= b_flags;
        avg_load  <= 1'b0;
        avg_sum   <= sum_total;
        if (b_flags.measure_done) begin
          distance <= d;
          if (wrap) begin
            avg_load     <= 1'b1;
            distance_sum <= '0;
            sample_count <= '0;
          end else begin
            distance_sum <= sum_total;
            sample_count <= cnt_inc;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `UERA_ASSERT(a_count_range, clk, rst, sample_count < CNT_W'(AVG_COUNT))

endmodule

// File: rtl/uera_avg.sv
module uera_avg #(
  parameter int AVG_COUNT = uera_pkg::AVG_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  uera_pkg::flags_t            flags_in,
  input  logic [uera_pkg::DIST_W-1:0] distance_in,
  input  logic                        avg_load,
  input  logic [uera_pkg::SUM_W-1:0]  avg_sum,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        trigger_level,
  output logic                        led_level,
  output logic                        measure_done,
  output logic                        no_echo,
  output logic [uera_pkg::DIST_W-1:0] distance_q8,
  output logic [uera_pkg::DIST_W-1:0] average_q8
);
  import uera_pkg::*;

  // divide by the block size as multiply by rounded-up reciprocal
  localparam int AVG_SHIFT = SUM_W + $clog2(AVG_COUNT);
  localparam int MW        = SUM_W + 1;
  localparam int PRW       = SUM_W + MW;
  localparam logic [MW-1:0] AVG_RECIP =
    MW'(((64'd1 << AVG_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

  flags_t           flags_q;
  logic [PRW-1:0]   avg_prod;
  logic             load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;
  assign avg_prod = PRW'(avg_sum) * PRW'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      average_q8 <= '0;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        flags_q     <= flags_in;
        distance_q8 <= distance_in;
        if (avg_load) begin
          average_q8 <= avg_prod[AVG_SHIFT+DIST_W-1:AVG_SHIFT];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign trigger_level = flags_q.trigger_level;
  assign led_level     = flags_q.led_level;
  assign measure_done  = flags_q.measure_done;
  assign no_echo       = flags_q.no_echo;

endmodule

// File: rtl/ultrasonic_echo_ranger_avg.sv
// channel  handshake            payload
// in       in_valid/in_ready    echo_level
// out      out_valid/out_ready  trigger_level led_level measure_done no_echo
//                               distance_q8 average_q8
// cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// one word in and one word out per cycle while out_ready is high, each result passes four register stages
// stages: phase sequencer, pulse times scale multiply, round and accumulate, average divide
// rst clears sequencer, sums and averages and loads default register values
// each stage holds its word while the next is full; in_ready drops only when all four are full
// cfg_ready is always high
module ultrasonic_echo_ranger_avg #(
  parameter int AVG_COUNT  = uera_pkg::AVG_COUNT_DEF,
  parameter int TIMER_BITS = uera_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           trigger_level,
  output logic                           led_level,
  output logic                           measure_done,
  output logic                           no_echo,
  output logic [uera_pkg::DIST_W-1:0]    distance_q8,
  output logic [uera_pkg::DIST_W-1:0]    average_q8,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uera_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uera_pkg::SCALE_W-1:0]   cfg_data
);
  import uera_pkg::*;

  cfg_t                  regs;

  logic                  seq_valid, seq_ready;
  flags_t                seq_flags;
  logic [TIMER_BITS-1:0] seq_pulse;

  logic                  dist_valid, dist_ready;
  flags_t                dist_flags;
  logic [DIST_W-1:0]     dist_value;
  logic                  dist_avg_load;
  logic [SUM_W-1:0]      dist_avg_sum;

  uera_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  uera_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .echo_level (echo_level),
    .regs       (regs),
    .out_valid  (seq_valid),
    .out_ready  (seq_ready),
    .flags      (seq_flags),
    .pulse      (seq_pulse)
  );

  uera_dist #(
    .TIMER_BITS (TIMER_BITS),
    .AVG_COUNT  (AVG_COUNT)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .flags_in  (seq_flags),
    .pulse     (seq_pulse),
    .scale     (regs.scale_q24),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .flags_out (dist_flags),
    .distance  (dist_value),
    .avg_load  (dist_avg_load),
    .avg_sum   (dist_avg_sum)
  );

  uera_avg #(
    .AVG_COUNT (AVG_COUNT)
  ) u_avg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (dist_valid),
    .in_ready      (dist_ready),
    .flags_in      (dist_flags),
    .distance_in   (dist_value),
    .avg_load      (dist_avg_load),
    .avg_sum       (dist_avg_sum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .led_level     (led_level),
    .measure_done  (measure_done),
    .no_echo       (no_echo),
    .distance_q8   (distance_q8),
    .average_q8    (average_q8)
  );

endmodule

// File: test/ultrasonic_echo_ranger_avg_tb.sv
module ultrasonic_echo_ranger_avg_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uera_pkg::*;

  localparam int AVG_N = AVG_COUNT_DEF;
  localparam int unsigned TICK_MAX = (1 << TIMER_BITS_DEF) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAD = 8;
  localparam int SEGMENTS = 12;
  localparam int SEG_TICKS = 50;
  localparam int LONG_PULSE = 16400;
  localparam int SCRIPT_ROWS = 39;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [2:0] {
    PH_LED_ON, PH_LED_OFF, PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT, PH_PULSE
  } ranger_phase_t;

  typedef struct packed {
    logic              trig;
    logic              led;
    logic              done;
    logic              noecho;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] avg;
  } tick_word_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [SCALE_W-1:0]    data;
    logic                  echo;
    logic                  typed;
    tick_word_t            want;
  } script_row_t;

  localparam tick_word_t LED_TICK =
    '{trig: 1'b0, led: 1'b1, done: 1'b0, noecho: 1'b0, distance: '0, avg: '0};
  localparam tick_word_t TRIG_TICK =
    '{trig: 1'b1, led: 1'b0, done: 1'b0, noecho: 1'b0, distance: '0, avg: '0};
  localparam tick_word_t MISS_TICK =
    '{trig: 1'b0, led: 1'b0, done: 1'b1, noecho: 1'b1, distance: '0, avg: '0};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 echo_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 trigger_level;
  logic                 led_level;
  logic                 measure_done;
  logic                 no_echo;
  logic [DIST_W-1:0]    distance_q8;
  logic [DIST_W-1:0]    average_q8;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0]   cfg_data;

  cfg_t              ranger_cfg;
  ranger_phase_t     seq_phase;
  int unsigned       seq_ticks;
  int unsigned       pulse_len;
  logic [DIST_W-1:0] dist_latest;
  logic [DIST_W-1:0] avg_held;
  logic [SUM_W-1:0]  dist_acc;
  logic [3:0]        meas_count;

  tick_word_t  expected_q [$];
  script_row_t script [SCRIPT_ROWS];
  int          fail_count;
  int          ticks_sent;
  int          meas_total;
  int          no_echo_total;
  int          avg_updates;
  int          saturated_total;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          idle_cycles;
  int          done_mark;
  bit          plan_noise;
  int unsigned plan_rise;
  int unsigned plan_width;

  ultrasonic_echo_ranger_avg dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .led_level     (led_level),
    .measure_done  (measure_done),
    .no_echo       (no_echo),
    .distance_q8   (distance_q8),
    .average_q8    (average_q8),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned phase_len(ranger_phase_t p);
    int unsigned v;
    case (p)
      PH_LED_ON:    v = ranger_cfg.led_on_us;
      PH_LED_OFF:   v = ranger_cfg.led_off_us;
      PH_TRIG_LOW:  v = ranger_cfg.trigger_low_us;
      PH_TRIG_HIGH: v = ranger_cfg.trigger_high_us;
      default:      v = ranger_cfg.listen_timeout_us;
    endcase
    return (v > TICK_MAX) ? TICK_MAX : v;
  endfunction

  task automatic reset_ranger();
    ranger_cfg = CFG_RESET;
    seq_phase = PH_LED_ON;
    seq_ticks = 0;
    pulse_len = 0;
    dist_latest = '0;
    avg_held = '0;
    dist_acc = '0;
    meas_count = '0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    case (idx)
      REG_TRIG_LOW:  ranger_cfg.trigger_low_us = data[LEN_W-1:0];
      REG_TRIG_HIGH: ranger_cfg.trigger_high_us = data[LEN_W-1:0];
      REG_LISTEN:    ranger_cfg.listen_timeout_us = data[LEN_W-1:0];
      REG_LED_ON:    ranger_cfg.led_on_us = data[LEN_W-1:0];
      REG_LED_OFF:   ranger_cfg.led_off_us = data[LEN_W-1:0];
      REG_SCALE:     ranger_cfg.scale_q24 = data;
      default: ;
    endcase
  endtask

  task automatic close_measurement(input bit ok, inout tick_word_t w);
    logic [63:0]       scaled;
    logic [DIST_W-1:0] d;
    d = '0;
    if (ok) begin
      scaled = (64'(pulse_len) * 64'(ranger_cfg.scale_q24) + 64'd32768) >> 16;
      if (scaled > 64'(DIST_MAX)) begin
        d = DIST_MAX;
        saturated_total++;
      end else begin
        d = scaled[DIST_W-1:0];
      end
    end
    w.done = 1'b1;
    w.noecho = !ok;
    dist_latest = d;
    dist_acc = dist_acc + SUM_W'(d);
    meas_count = meas_count + 4'd1;
    if (meas_count >= AVG_N) begin
      avg_held = DIST_W'(dist_acc / AVG_N);
      dist_acc = '0;
      meas_count = '0;
      avg_updates++;
    end
    seq_phase = PH_LED_ON;
    seq_ticks = 0;
    pulse_len = 0;
    meas_total++;
    if (!ok) no_echo_total++;
  endtask

  task automatic step_ranger(input logic echo, output tick_word_t w);
    bit last;
    w = '0;
    // zero-length led and trigger phases take no tick
    while (seq_phase < PH_WAIT && phase_len(seq_phase) == 0) begin
      seq_phase = ranger_phase_t'(seq_phase + 1);
      seq_ticks = 0;
    end
    last = (seq_ticks + 1 >= phase_len(seq_phase));
    if (seq_phase < PH_WAIT) begin
      w.led = (seq_phase == PH_LED_ON);
      w.trig = (seq_phase == PH_TRIG_HIGH);
      if (last) begin
        seq_phase = ranger_phase_t'(seq_phase + 1);
        seq_ticks = 0;
        pulse_len = 0;
      end else begin
        seq_ticks++;
      end
    end else if (seq_phase == PH_WAIT) begin
      if (echo) begin
        pulse_len = 1;
        if (last) begin
          close_measurement(1'b0, w);
        end else begin
          seq_phase = PH_PULSE;
          seq_ticks++;
        end
      end else if (last) begin
        close_measurement(1'b0, w);
      end else begin
        seq_ticks++;
      end
    end else begin
      if (!echo) begin
        close_measurement(1'b1, w);
      end else if (last) begin
        close_measurement(1'b0, w);
      end else begin
        if (pulse_len < TICK_MAX) pulse_len++;
        seq_ticks++;
      end
    end
    w.distance = dist_latest;
    w.avg = avg_held;
  endtask

  // echo shape for the next measurement
  task automatic new_plan();
    int unsigned span;
    span = phase_len(PH_WAIT);
    plan_noise = ($urandom_range(0, 99) < 15);
    plan_rise = $urandom_range(0, span);
    plan_width = $urandom_range(1, span + 1);
  endtask

  function automatic logic choose_echo();
    if (seq_phase < PH_WAIT || plan_noise) return 1'($urandom_range(0, 1));
    if (seq_phase == PH_WAIT) return seq_ticks >= plan_rise;
    return pulse_len < plan_width;
  endfunction

  function automatic script_row_t tick_row(logic echo);
    script_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.echo = echo;
    return r;
  endfunction

  function automatic script_row_t typed_row(logic echo, tick_word_t want);
    script_row_t r;
    r = tick_row(echo);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    script_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [SCALE_W-1:0] len_word(int unsigned top);
    return {4'($urandom_range(0, 15)), 16'($urandom_range(0, top))};
  endfunction

  task automatic send_tick(input logic echo, input bit typed, input tick_word_t want);
    tick_word_t w;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    step_ranger(echo, w);
    expected_q.push_back(typed ? want : w);
    if (w.done) new_plan();
    ticks_sent++;
    in_valid <= 1'b1;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic random_setup();
    write_reg(REG_LED_ON, len_word(3));
    write_reg(REG_LED_OFF, len_word(3));
    write_reg(REG_TRIG_LOW, len_word(3));
    write_reg(REG_TRIG_HIGH, len_word(3));
    write_reg(REG_LISTEN, len_word(16));
    write_reg(REG_SCALE, 20'($urandom()));
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 20'($urandom()));
    new_plan();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : word_check
    tick_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("output word with nothing expected");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("trigger_level", want.trig, trigger_level);
        check_field("led_level", want.led, led_level);
        check_field("measure_done", want.done, measure_done);
        check_field("no_echo", want.noecho, no_echo);
        check_field("distance_q8", want.distance, distance_q8);
        check_field("average_q8", want.avg, average_q8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    echo_level = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_cycles = 0;
    fail_count = 0;
    ticks_sent = 0;
    meas_total = 0;
    no_echo_total = 0;
    avg_updates = 0;
    saturated_total = 0;
    send_idle_pct = 35;
    recv_idle_pct = 72;
    reset_ranger();
    new_plan();

    script = '{
      typed_row(1'b0, LED_TICK),
      typed_row(1'b1, LED_TICK),
      reg_row(REG_LED_ON, 20'hFFFFF),
      typed_row(1'b0, LED_TICK),
      // led phase shortened below the count already reached
      reg_row(REG_LED_ON, 20'h00001),
      reg_row(REG_LED_OFF, 20'h00000),
      reg_row(REG_TRIG_LOW, 20'h00000),
      reg_row(REG_TRIG_HIGH, 20'h00002),
      reg_row(REG_LISTEN, 20'h00000),
      reg_row(REG_SCALE, 20'hFFFFF),
      reg_row(REG_SPARE_A, 20'h5A5A5),
      reg_row(REG_SPARE_B, 20'hFFFFF),
      typed_row(1'b1, LED_TICK),
      typed_row(1'b0, TRIG_TICK),
      typed_row(1'b1, TRIG_TICK),
      // zero listen timeout still gives one tick
      typed_row(1'b1, MISS_TICK),
      reg_row(REG_LED_OFF, 20'h00001),
      reg_row(REG_TRIG_LOW, 20'h00001),
      reg_row(REG_TRIG_HIGH, 20'h00001),
      reg_row(REG_LISTEN, 20'h00006),
      reg_row(REG_SCALE, CFG_RESET.scale_q24),
      tick_row(1'b1),
      tick_row(1'b0),
      tick_row(1'b1),
      tick_row(1'b0),
      tick_row(1'b0),
      tick_row(1'b1),
      tick_row(1'b1),
      tick_row(1'b0),
      tick_row(1'b0),
      tick_row(1'b1),
      tick_row(1'b0),
      tick_row(1'b1),
      // pulse still high at the listen timeout
      tick_row(1'b1),
      tick_row(1'b1),
      tick_row(1'b1),
      tick_row(1'b1),
      tick_row(1'b1),
      tick_row(1'b1)
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_tick(script[i].echo, script[i].typed, script[i].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 72;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setup();
      repeat (SEG_TICKS) send_tick(choose_echo(), 1'b0, '0);
    end

    // one pulse long enough to saturate the distance at full scale
    write_reg(REG_LED_ON, 20'd1);
    write_reg(REG_LED_OFF, 20'd1);
    write_reg(REG_TRIG_LOW, 20'd1);
    write_reg(REG_TRIG_HIGH, 20'd1);
    write_reg(REG_LISTEN, 20'h0FFFF);
    write_reg(REG_SCALE, 20'hFFFFF);
    plan_noise = 1'b0;
    plan_rise = 2;
    plan_width = LONG_PULSE;
    done_mark = meas_total;
    while (meas_total == done_mark) send_tick(choose_echo(), 1'b0, '0);

    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);

    $display("%0d echo ticks over %0d register settings, %0d measurements, %0d without echo",
             ticks_sent, SEGMENTS + 4, meas_total, no_echo_total);
    $display("%0d block averages taken, %0d saturated distances", avg_updates, saturated_total);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
